>>> rtl/checked_i64_alu_top_defines.svh
// Assertion macros for the checked 64-bit ALU.
// Used by checked_i64_alu_top; relies on i_clk and i_rst_n in the including module.
`ifndef CHECKED_I64_ALU_TOP_DEFINES_SVH
`define CHECKED_I64_ALU_TOP_DEFINES_SVH

// Clocked check, off while reset is asserted.
`define CIA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Implication checked in the same cycle.
`define CIA_ASSERT_IMP(lbl, ante, cons, msg) \
    `CIA_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

>>> rtl/cia_pkg.sv
// Shared types and codes for the checked 64-bit ALU.
// No dependencies.
package cia_pkg;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_CMP = 3'd4;

    localparam logic [2:0] PR_EQ = 3'd0;
    localparam logic [2:0] PR_NE = 3'd1;
    localparam logic [2:0] PR_LT = 3'd2;
    localparam logic [2:0] PR_LE = 3'd3;
    localparam logic [2:0] PR_GT = 3'd4;
    localparam logic [2:0] PR_GE = 3'd5;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_OVERFLOW = 3'd1;
    localparam logic [2:0] ST_DIV_ZERO = 3'd2;
    localparam logic [2:0] ST_DIV_OVF  = 3'd3;
    localparam logic [2:0] ST_BAD_PRED = 3'd4;

    localparam int unsigned DIV_STAGES = 64;
    localparam logic [63:0] MIN_S64 = 64'h8000_0000_0000_0000;

    // Result so far, plus what the divide tail still has to do.
    typedef struct packed {
        logic [63:0] value;
        logic [2:0]  status;
        logic        is_bool;
        logic        is_div;
        logic        div_neg;
    } t_side;

    typedef struct packed {
        t_side       side;
        logic        is_mul;
        logic        wrap;
        logic        mul_neg;
        logic [63:0] ma;
        logic [63:0] mb;
    } t_prep;

    typedef struct packed {
        t_side       side;
        logic [63:0] ma;
        logic [63:0] mb;
    } t_dvin;

    function automatic logic [63:0] magnitude(input logic [63:0] x);
        magnitude = x[63] ? (64'd0 - x) : x;
    endfunction

endpackage

>>> rtl/checked_i64_alu_top.sv
// Checked signed 64-bit ALU: add, sub, mul, div, compare with overflow traps.
// Pipeline stages: decode 1, multiplier 3, divider 64 (one bit per stage), output 1.
// Throughput one item per cycle; the whole pipeline advances together, so an output
// stall holds every stage and bubbles travel with the data rather than being squeezed out.
// Reset (i_rst_n low, synchronous) clears all valid bits; data registers are not reset.
// Depends on cia_pkg, cia_prep, cia_mul, cia_div and checked_i64_alu_top_defines.svh.
`include "checked_i64_alu_top_defines.svh"
module checked_i64_alu_top import cia_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_op,
    input  logic               i_wrapping,
    input  logic [2:0]         i_predicate,
    input  logic signed [63:0] i_left_operand,
    input  logic signed [63:0] i_right_operand,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [63:0] o_value,
    output logic               o_is_boolean,
    output logic [2:0]         o_status
);

    // Single advance enable: every stage moves when the output slot is free or drains.
    logic        adv;
    logic        prep_vld, mul_vld, div_vld;
    t_prep       prep;
    t_dvin       dv;
    t_side       side;
    logic [63:0] quo;
    logic [63:0] n_value;

    logic        r_out_vld;
    logic [63:0] r_value;
    logic        r_is_bool;
    logic [2:0]  r_status;

    assign adv        = !r_out_vld || i_out_ready;
    assign o_in_ready = adv;

    cia_prep u_prep (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (adv),
        .i_vld           (i_in_valid),
        .i_op            (i_op),
        .i_wrapping      (i_wrapping),
        .i_predicate     (i_predicate),
        .i_left_operand  (i_left_operand),
        .i_right_operand (i_right_operand),
        .o_vld           (prep_vld),
        .o_prep          (prep)
    );

    cia_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (prep_vld),
        .i_prep  (prep),
        .o_vld   (mul_vld),
        .o_dv    (dv)
    );

    // Every item runs through the divider; only divide items use its quotient.
    cia_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (mul_vld),
        .i_dv    (dv),
        .o_vld   (div_vld),
        .o_side  (side),
        .o_quo   (quo)
    );

    // Quotient sign fix (truncation toward zero).
    always_comb begin
        if (side.is_div) begin
            n_value = side.div_neg ? (64'd0 - quo) : quo;
        end else begin
            n_value = side.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_value   <= n_value;
            r_is_bool <= side.is_bool;
            r_status  <= side.status;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_value      = r_value;
    assign o_is_boolean = r_is_bool;
    assign o_status     = r_status;

    `CIA_ASSERT_IMP(a_err_zero, o_out_valid && o_status != ST_OK, o_value == '0 && !o_is_boolean, "error item carries data")
    `CIA_ASSERT_IMP(a_bool_ok, o_out_valid && o_is_boolean, o_value[63:1] == '0 && o_status == ST_OK, "bad compare result")
    `CIA_ASSERT_IMP(a_stall_only, !o_in_ready, o_out_valid && !i_out_ready, "input blocked without output stall")

endmodule

>>> rtl/cia_prep.sv
// First stage: decode, add/sub/compare results, error checks, operand magnitudes.
// Depends on cia_pkg.
module cia_prep import cia_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  logic [2:0]         i_op,
    input  logic               i_wrapping,
    input  logic [2:0]         i_predicate,
    input  logic signed [63:0] i_left_operand,
    input  logic signed [63:0] i_right_operand,
    output logic               o_vld,
    output t_prep              o_prep
);

    logic        r_vld;
    t_prep       r_prep;
    t_prep       n_prep;
    logic [63:0] a, b, sum, dif;
    logic        add_ovf, sub_ovf, lt, gt, eq, cmp;

    always_comb begin
        a       = i_left_operand;
        b       = i_right_operand;
        sum     = a + b;
        dif     = a - b;
        add_ovf = (a[63] ^ sum[63]) & (b[63] ^ sum[63]);
        sub_ovf = (a[63] ^ b[63]) & (a[63] ^ dif[63]);
        lt      = i_left_operand < i_right_operand;
        gt      = i_right_operand < i_left_operand;
        eq      = a == b;

        n_prep              = '0;
        n_prep.wrap         = i_wrapping;
        n_prep.ma           = magnitude(a);
        n_prep.mb           = magnitude(b);
        n_prep.mul_neg      = (a[63] ^ b[63]) && (a != '0) && (b != '0);
        n_prep.side.status  = ST_OK;
        cmp                 = 1'b0;

        case (i_op)
            OP_ADD: begin
                if (!i_wrapping && add_ovf) n_prep.side.status = ST_OVERFLOW;
                else                        n_prep.side.value  = sum;
            end
            OP_SUB: begin
                if (!i_wrapping && sub_ovf) n_prep.side.status = ST_OVERFLOW;
                else                        n_prep.side.value  = dif;
            end
            OP_MUL: begin
                n_prep.is_mul = 1'b1;
            end
            OP_DIV: begin
                if (b == '0) begin
                    n_prep.side.status = ST_DIV_ZERO;
                end else if (a == MIN_S64 && b == '1) begin
                    n_prep.side.status = ST_DIV_OVF;
                end else begin
                    n_prep.side.is_div  = 1'b1;
                    n_prep.side.div_neg = a[63] ^ b[63];
                end
            end
            OP_CMP: begin
                case (i_predicate)
                    PR_EQ:   cmp = eq;
                    PR_NE:   cmp = !eq;
                    PR_LT:   cmp = lt;
                    PR_LE:   cmp = !gt;
                    PR_GT:   cmp = gt;
                    PR_GE:   cmp = !lt;
                    default: n_prep.side.status = ST_BAD_PRED;
                endcase
                if (n_prep.side.status == ST_OK) begin
                    n_prep.side.value   = {63'd0, cmp};
                    n_prep.side.is_bool = 1'b1;
                end
            end
            default: n_prep.side.status = ST_BAD_PRED;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prep <= n_prep;
        end
    end

    assign o_vld  = r_vld;
    assign o_prep = r_prep;

endmodule

>>> rtl/cia_mul.sv
// Three-stage 64x64 magnitude multiplier with signed overflow check.
// Depends on cia_pkg.
module cia_mul import cia_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_vld,
    input  t_prep i_prep,
    output logic  o_vld,
    output t_dvin o_dv
);

    logic [2:0]  r_vld;
    t_prep       r_pa, r_pb;
    logic [63:0] r_ll, r_lh, r_hl, r_hh;
    logic [63:0] r_lo, r_hi;
    t_dvin       r_dv, n_dv;
    logic [33:0] mid;
    logic [63:0] n_hi, prod;
    logic        ovf;

    // partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pa <= i_prep;
            r_ll <= i_prep.ma[31:0]  * i_prep.mb[31:0];
            r_lh <= i_prep.ma[31:0]  * i_prep.mb[63:32];
            r_hl <= i_prep.ma[63:32] * i_prep.mb[31:0];
            r_hh <= i_prep.ma[63:32] * i_prep.mb[63:32];
        end
    end

    // column sums
    always_comb begin
        mid  = {2'd0, r_ll[63:32]} + {2'd0, r_lh[31:0]} + {2'd0, r_hl[31:0]};
        n_hi = r_hh + {32'd0, r_lh[63:32]} + {32'd0, r_hl[63:32]} + {62'd0, mid[33:32]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pb <= r_pa;
            r_lo <= {mid[31:0], r_ll[31:0]};
            r_hi <= n_hi;
        end
    end

    // sign fix and overflow
    always_comb begin
        ovf  = (r_hi != '0) || (r_pb.mul_neg ? (r_lo > MIN_S64) : (r_lo >= MIN_S64));
        prod = r_pb.mul_neg ? (64'd0 - r_lo) : r_lo;
        n_dv.side = r_pb.side;
        n_dv.ma   = r_pb.ma;
        n_dv.mb   = r_pb.mb;
        if (r_pb.is_mul) begin
            if (!r_pb.wrap && ovf) begin
                n_dv.side.status = ST_OVERFLOW;
                n_dv.side.value  = '0;
            end else begin
                n_dv.side.value  = prod;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dv <= n_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    assign o_vld = r_vld[2];
    assign o_dv  = r_dv;

endmodule

>>> rtl/cia_div.sv
// Restoring divider, one quotient bit per pipeline stage.
// Depends on cia_pkg.
module cia_div import cia_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_vld,
    input  t_dvin       i_dv,
    output logic        o_vld,
    output t_side       o_side,
    output logic [63:0] o_quo
);

    logic        r_vld [DIV_STAGES];
    t_side       r_side[DIV_STAGES];
    logic [63:0] r_rem [DIV_STAGES];
    logic [63:0] r_dvd [DIV_STAGES];
    logic [63:0] r_dsr [DIV_STAGES];

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        logic        v_in;
        t_side       s_in;
        logic [63:0] rem_in, dvd_in, dsr_in;
        logic [64:0] part, diff;
        logic        ge;

        if (g == 0) begin : g_first
            assign v_in   = i_vld;
            assign s_in   = i_dv.side;
            assign rem_in = '0;
            assign dvd_in = i_dv.ma;
            assign dsr_in = i_dv.mb;
        end else begin : g_next
            assign v_in   = r_vld[g-1];
            assign s_in   = r_side[g-1];
            assign rem_in = r_rem[g-1];
            assign dvd_in = r_dvd[g-1];
            assign dsr_in = r_dsr[g-1];
        end

        always_comb begin
            part = {rem_in, dvd_in[63]};
            diff = part - {1'b0, dsr_in};
            ge   = part >= {1'b0, dsr_in};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[g] <= s_in;
                r_dsr[g]  <= dsr_in;
                r_rem[g]  <= ge ? diff[63:0] : part[63:0];
                r_dvd[g]  <= {dvd_in[62:0], ge};
            end
        end
    end

    assign o_vld  = r_vld[DIV_STAGES-1];
    assign o_side = r_side[DIV_STAGES-1];
    assign o_quo  = r_dvd[DIV_STAGES-1];

endmodule
